// ----- sv/sbxks_pkg.sv -----
// Shared types, constants and the letter test for the single-byte XOR key search.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package sbxks_pkg;

  // Key space and score sizing
  localparam int NUM_KEYS = 256;
  localparam int KEY_W    = $clog2(NUM_KEYS);
  localparam int SCORE_W  = 13;
  localparam int MAX_LEN  = 4096;

  // Stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic count;     // add one byte into every key counter
    logic clr_best;  // restart the running maximum
    logic shift;     // advance the sweep by one key
    logic load;      // copy the winner into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic sweep_last;  // the sweep is looking at the highest key
  } status_t;

  // True for A-Z, a-z and space
  function automatic logic is_letter_or_space(input logic [7:0] d);
    logic [7:0] low;
    low = d | 8'h20;
    return (d == 8'h20) || ((low >= 8'h61) && (low <= 8'h7A));
  endfunction

endpackage

// ----- sv/sbxks_ctrl.sv -----
// Controller for the key search: sequences byte counting, the argmax sweep
// and the result handoff. Depends on sbxks_pkg.
`timescale 1ns / 1ps

module sbxks_ctrl
  import sbxks_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer;

  assign in_xfer = in_valid_i && in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_last_i) state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (status_i.sweep_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.count    = in_xfer;
        cmd_o.clr_best = in_xfer && in_last_i;
      end
      ST_SWEEP: begin
        cmd_o.shift = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  // Hold the result valid until its transfer; a new load takes priority
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- sv/sbxks_bank.sv -----
// Bank of per-key letter counters: counts in parallel, then shifts toward
// entry zero during the sweep, emptying itself. Depends on sbxks_pkg.
`timescale 1ns / 1ps

module sbxks_bank
  import sbxks_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic [7:0]         data_byte_i,
  output logic [SCORE_W-1:0] head_score_o
);

  localparam logic [SCORE_W-1:0] MaxScore = SCORE_W'(MAX_LEN);

  logic [SCORE_W-1:0] score_q [NUM_KEYS];
  logic [SCORE_W-1:0] score_d [NUM_KEYS];
  logic [NUM_KEYS-1:0] hit;

  // Letter test for each candidate key
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_hit
    assign hit[k] = is_letter_or_space(data_byte_i ^ KEY_W'(k));
  end

  // Count with saturation, or shift down one lane with zero filling the top
  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      score_d[i] = score_q[i];
      if (cmd_i.shift) begin
        score_d[i] = (i == NUM_KEYS - 1) ? '0 : score_q[(i + 1) % NUM_KEYS];
      end else if (cmd_i.count && hit[i] && (score_q[i] < MaxScore)) begin
        score_d[i] = score_q[i] + SCORE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KEYS; i++) score_q[i] <= '0;
    end else begin
      for (int i = 0; i < NUM_KEYS; i++) score_q[i] <= score_d[i];
    end
  end

  assign head_score_o = score_q[0];

endmodule

// ----- sv/sbxks_argmax.sv -----
// Running maximum over the swept scores plus the output result register.
// Depends on sbxks_pkg.
`timescale 1ns / 1ps

module sbxks_argmax
  import sbxks_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic [SCORE_W-1:0] head_score_i,
  output status_t            status_o,
  output logic [KEY_W-1:0]   best_key_o,
  output logic [SCORE_W-1:0] best_score_o,
  output logic               key_found_o
);

  logic [KEY_W-1:0]   idx_q;
  logic [KEY_W-1:0]   run_key_q;
  logic [SCORE_W-1:0] run_score_q;
  logic [KEY_W-1:0]   res_key_q;
  logic [SCORE_W-1:0] res_score_q;

  // Sweep key index; wraps to zero after the last key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.shift) begin
      idx_q <= idx_q + KEY_W'(1);
    end
  end

  assign status_o.sweep_last = (idx_q == KEY_W'(NUM_KEYS - 1));

  // Keep the first strictly higher score, so ties go to the lower key
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_best) begin
      run_key_q   <= '0;
      run_score_q <= '0;
    end else if (cmd_i.shift && (head_score_i > run_score_q)) begin
      run_key_q   <= idx_q;
      run_score_q <= head_score_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_key_q   <= run_key_q;
      res_score_q <= run_score_q;
    end
  end

  assign best_key_o   = res_key_q;
  assign best_score_o = res_score_q;
  assign key_found_o  = (res_score_q != '0);

endmodule

// ----- sv/single_byte_xor_key_search_core.sv -----
// Top level of the single-byte XOR key search: stream ports, controller and
// datapath. Depends on sbxks_pkg, sbxks_ctrl, sbxks_bank and sbxks_argmax.
`timescale 1ns / 1ps

// Message bytes stream in one per cycle while idle; each transfer updates all
// 256 key counters at once, and tlast closes the message. After the last byte
// the block sweeps the counters one key per cycle through the single compare
// unit that the counter bank shifts through; the sweep also clears the
// counters. A finish state then loads the result register. Input stalls
// through the sweep and the finish state, longer while the previous result
// has not yet left the output. Bytes of the next message are taken while a
// result still waits on the output. Each count saturates at 4096. The result
// gives the lowest key with the highest count, that count, and a found flag
// in tuser.

module single_byte_xor_key_search_core
  import sbxks_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic                  s_axis_tlast_i,   // last_byte
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // [7:0] best_key, [20:8] best_score
  output logic                  m_axis_tuser_o    // key_found
);

  cmd_t               cmd;
  status_t            status;
  logic [SCORE_W-1:0] head_score;
  logic [KEY_W-1:0]   best_key;
  logic [SCORE_W-1:0] best_score;

  sbxks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sbxks_bank u_bank (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .data_byte_i  (s_axis_tdata_i[7:0]),
    .head_score_o (head_score)
  );

  sbxks_argmax u_argmax (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .head_score_i (head_score),
    .status_o     (status),
    .best_key_o   (best_key),
    .best_score_o (best_score),
    .key_found_o  (m_axis_tuser_o)
  );

  // Pack the result, zero-filled to whole bytes
  assign m_axis_tdata_o = {(OUT_DATA_W - KEY_W - SCORE_W)'(0), best_score, best_key};

endmodule

// ----- sv/sbxks_checker.sv -----
// Port-level checker for the key search core, attached by bind.
// Depends on sbxks_pkg and single_byte_xor_key_search_core.
`timescale 1ns / 1ps

module sbxks_checker
  import sbxks_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  s_axis_tlast_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                  m_axis_tuser_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Found flag agrees with the score
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == (m_axis_tdata_o[20:8] != 13'd0)))
    else $error("key_found disagrees with best_score");

  // No key found reports key zero
  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[7:0] == 8'd0)
    else $error("nonzero key without a score");

  // Score never passes saturation and padding stays zero
  a_score_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[20:8] <= 13'(MAX_LEN)) &&
                        (m_axis_tdata_o[23:21] == 3'd0))
    else $error("score out of range");

  // Input stalls for the sweep after a closing transfer
  a_sweep_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input taken during the sweep");

endmodule

bind single_byte_xor_key_search_core sbxks_checker u_sbxks_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ----- sim/key_search_checker.sv -----
// Checker for the single-byte XOR key search: watches both stream channels,
// predicts each message result and compares it field by field.
// Depends on sbxks_pkg for widths, key count and the saturation limit.
`timescale 1ns / 1ps

module key_search_checker
  import sbxks_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic                  s_tlast_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  input  logic                  m_tuser_i,
  output int                    err_cnt_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic               found;
  } search_result_t;

  // Per-key letter counts of the message in flight, and results still owed
  logic [SCORE_W-1:0] key_tally [NUM_KEYS];
  search_result_t     best_q [$];
  int                 mism_cnt = 0;

  // A-Z, a-z or space
  function automatic logic plain_hit(input logic [7:0] d);
    return (d == 8'h20) || ((d >= 8'h41) && (d <= 8'h5A)) ||
           ((d >= 8'h61) && (d <= 8'h7A));
  endfunction

  function automatic void clear_tally();
    foreach (key_tally[k]) key_tally[k] = '0;
  endfunction

  // Count one byte for every key; on the last byte pick the winner
  task automatic tally_byte(input logic [7:0] b, input logic l);
    search_result_t res;
    res = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (plain_hit(b ^ KEY_W'(k)) && (key_tally[k] < MAX_LEN)) key_tally[k]++;
    end
    if (l) begin
      // strict compare keeps the lowest key on a tie
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (key_tally[k] > res.score) begin
          res.score = key_tally[k];
          res.key   = KEY_W'(k);
        end
      end
      res.found = (res.score != 0);
      best_q = {best_q, res};
      clear_tally();
    end
  endtask

  // Report the first few, count all
  task automatic flag(input string msg);
    if (mism_cnt < 10) $display("%0t ns: %s", $time, msg);
    mism_cnt++;
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk_i) begin : watch
    search_result_t got;
    search_result_t want;
    if (!rst_ni) begin
      clear_tally();
      best_q.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) tally_byte(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) begin
        got.key   = m_tdata_i[7:0];
        got.score = m_tdata_i[20:8];
        got.found = m_tuser_i;
        if (best_q.size() == 0) begin
          flag($sformatf("result with none pending: key %0d score %0d found %0d",
                         got.key, got.score, got.found));
        end else begin
          want = best_q.pop_front();
          if (got.key != want.key)
            flag($sformatf("best_key mismatch: expected %0d, got %0d", want.key, got.key));
          if (got.score != want.score)
            flag($sformatf("best_score mismatch: expected %0d, got %0d",
                           want.score, got.score));
          if (got.found != want.found)
            flag($sformatf("key_found mismatch: expected %0d, got %0d",
                           want.found, got.found));
        end
      end
    end
    pending_o <= best_q.size();
    err_cnt_o <= mism_cnt;
  end

endmodule

// ----- sim/tb_single_byte_xor_key_search_core.sv -----
// Testbench top for single_byte_xor_key_search_core: drives ciphertext
// messages with random stalls and gives the verdict. Uses key_search_checker.
`timescale 1ns / 1ps

module tb_single_byte_xor_key_search_core;
  import sbxks_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_BYTES = 460;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  int src_idle = 0;
  int dst_idle = 0;
  int cycles = 0;
  int fail_cnt;
  int pending;

  single_byte_xor_key_search_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  key_search_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tlast_i  (s_tlast),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .err_cnt_o  (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Stall the result channel at random
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= dst_idle);
  end

  // Hard stop on a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Random letter or space of the plaintext alphabet
  function automatic logic [7:0] plain_char();
    int idx;
    idx = $urandom_range(52);
    if (idx < 26) return 8'(8'h41 + idx);
    if (idx < 52) return 8'(8'h61 + idx - 26);
    return 8'h20;
  endfunction

  // Hold one byte until its transfer, with random gaps ahead of it
  task automatic send_byte(input logic [7:0] b, input logic l);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      s_tdata  <= IN_DATA_W'($urandom);
      s_tlast  <= 1'($urandom);
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // Plaintext under one key, with some bytes replaced by noise
  task automatic send_message(input int len, input logic [7:0] key, input int noise_pct);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_pct) b = 8'($urandom);
      else b = plain_char() ^ key;
      send_byte(b, i == len - 1);
    end
  endtask

  // Drop valid and hold off until every owed result has been taken
  task automatic wait_results();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mostly short messages, a few longer ones
  task automatic run_random(input int n_bytes);
    int sent;
    int len;
    sent = 0;
    while (sent < n_bytes) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
      send_message(len, 8'($urandom_range(255)), ($urandom_range(9) < 8) ? 10 : 60);
      sent += len;
    end
  endtask

  initial begin : stimulus
    string hello;
    logic [7:0] one_byte [7];
    hello = "Hello world";
    one_byte = '{8'h00, 8'hFF, 8'h20, 8'h7F, 8'h80, 8'h55, 8'hAA};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle = 25;
    dst_idle = 53;
    // One-byte messages, including the byte extremes; every one ties many keys
    foreach (one_byte[i]) send_byte(one_byte[i], 1'b1);
    // A short sentence under a fixed key
    for (int i = 0; i < hello.len(); i++) send_byte(hello[i] ^ 8'hC3, i == hello.len() - 1);
    run_random(RANDOM_BYTES);
    wait_results();

    src_idle = 53;
    dst_idle = 25;
    run_random(RANDOM_BYTES);
    wait_results();

    src_idle = 0;
    dst_idle = 0;
    run_random(RANDOM_BYTES);
    @(negedge clk_i);
    s_tvalid <= 1'b0;

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/sbxks_pkg.sv
sv/sbxks_ctrl.sv
sv/sbxks_bank.sv
sv/sbxks_argmax.sv
sv/single_byte_xor_key_search_core.sv
sv/sbxks_checker.sv
sim/key_search_checker.sv
sim/tb_single_byte_xor_key_search_core.sv
